>>> rtl/vdts_pkg.sv
// Package for the video dot timing and scroll engine.
// Holds the operation codes, frame timing constants and the address stepping functions.
// No dependencies.
package vdts_pkg;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_CTRL   = 3'd1,
      OP_MASK   = 3'd2,
      OP_STATUS = 3'd3,
      OP_SCROLL = 3'd4,
      OP_ADDR   = 3'd5,
      OP_DATA   = 3'd6
   } op_type;

   localparam int AddrWidth  = 15;
   localparam int CountWidth = 9;

   // Frame geometry in dots and scanlines.
   localparam logic [9:0] DotsPerLine  = 10'd341;
   localparam logic [8:0] LastDot      = 9'd340;
   localparam logic [8:0] SkipDot      = 9'd339;
   localparam logic [8:0] VisibleLines = 9'd240;
   localparam logic [8:0] VblankLine   = 9'd241;
   localparam logic [8:0] VisibleWidth = 9'd256;
   localparam logic [8:0] StepYDot     = 9'd257;
   localparam logic [8:0] HorizDot     = 9'd258;
   localparam logic [8:0] PulseDot     = 9'd260;
   localparam logic [8:0] VertFirstDot = 9'd281;
   localparam logic [8:0] VertLastDot  = 9'd304;
   localparam logic [8:0] ResetLine    = 9'd261;

   localparam logic [14:0] HorizBits = 15'h041F;
   localparam logic [14:0] VertBits  = 15'h7BE0;

   localparam logic [4:0] CoarseMax  = 5'd31;
   localparam logic [4:0] CoarseWrap = 5'd29;

   // Moves to the next tile column, flipping the horizontal nametable at the edge.
   function automatic logic [14:0] step_coarse_x(input logic [14:0] addr);
      logic [14:0] res;
      res = addr;
      if (addr[4:0] == CoarseMax) begin
         res[4:0] = 5'd0;
         res[10]  = ~addr[10];
      end else begin
         res[4:0] = addr[4:0] + 5'd1;
      end
      return res;
   endfunction

   // Moves down one pixel row; after tile row 29 the vertical nametable flips, and row 31 wraps without a flip.
   function automatic logic [14:0] step_y(input logic [14:0] addr);
      logic [14:0] res;
      logic [4:0]  cy;
      res = addr;
      cy  = addr[9:5];
      if (addr[14:12] != 3'd7) begin
         res[14:12] = addr[14:12] + 3'd1;
      end else begin
         res[14:12] = 3'd0;
         if (cy == CoarseWrap) begin
            res[9:5] = 5'd0;
            res[11]  = ~addr[11];
         end else if (cy == CoarseMax) begin
            res[9:5] = 5'd0;
         end else begin
            res[9:5] = cy + 5'd1;
         end
      end
      return res;
   endfunction

   function automatic logic [14:0] copy_bits(input logic [14:0] cur, input logic [14:0] tmp,
                                             input logic [14:0] bits);
      return (cur & ~bits) | (tmp & bits);
   endfunction

endpackage

>>> rtl/video_dot_timing_scroll_engine.sv
// Top level of the video dot timing and scroll engine.
// Depends on vdts_pkg for operation codes, timing constants and address stepping.
// A request is held in the request register, and its result then in the response register.
// One request per cycle while responses are taken; the state update is a single pass of logic
// between the request register and the response register.
// Reset (synchronous, active high) loads the power-up state: scanline 261, dot 0,
// all addresses, latches and flags zero, write toggle set, pre-render line 261.
module video_dot_timing_scroll_engine (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_operation,
   input  logic [7:0]                       req_data_byte,
   // Response channel.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [vdts_pkg::AddrWidth-1:0]   rsp_vram_address,
   output logic [2:0]                       rsp_fine_scroll_x,
   output logic                             rsp_nmi_level,
   output logic [7:0]                       rsp_status_data,
   output logic                             rsp_frame_done,
   output logic                             rsp_scanline_pulse,
   output logic [vdts_pkg::CountWidth-1:0]  rsp_dot_index,
   output logic [vdts_pkg::CountWidth-1:0]  rsp_scanline_index,
   // Configuration: index of the pre-render scanline.
   input  logic                             csr_write_enable,
   input  logic [vdts_pkg::CountWidth-1:0]  csr_write_data
);
   import vdts_pkg::*;

   // Handshake and request register.
   logic   req_fire;
   logic   exec_fire;
   logic   s1_valid_ff, s1_valid_in;
   op_type s1_op_ff;
   logic [7:0] s1_data_ff;
   logic   rsp_valid_ff, rsp_valid_in;

   // Configuration register.
   logic [CountWidth-1:0] last_line_ff, last_line_in;

   // Architectural state.
   logic [AddrWidth-1:0]  cur_addr_ff, cur_addr_in;
   logic [AddrWidth-1:0]  tmp_addr_ff, tmp_addr_in;
   logic [2:0]            fine_x_ff, fine_x_in;
   logic                  first_wr_ff, first_wr_in;
   logic [7:0]            ctrl_ff, ctrl_in;
   logic [7:0]            mask_ff, mask_in;
   logic                  vblank_ff, vblank_in;
   logic [CountWidth-1:0] dot_ff, dot_in;
   logic [CountWidth-1:0] line_ff, line_in;
   logic                  odd_ff, odd_in;

   // Per-request results.
   logic [7:0] status_in;
   logic       frame_in;
   logic       pulse_in;

   // Response payload registers.
   logic [AddrWidth-1:0]  out_addr_ff;
   logic [2:0]            out_fine_x_ff;
   logic                  out_nmi_ff;
   logic [7:0]            out_status_ff;
   logic                  out_frame_ff;
   logic                  out_pulse_ff;
   logic [CountWidth-1:0] out_dot_ff;
   logic [CountWidth-1:0] out_line_ff;

   // Tick decode helpers.
   logic                  bg_on, render_on, both_on;
   logic                  coarse_hit;
   logic [2:0]            fine_sum;
   logic [CountWidth-1:0] dot_eff;
   logic [9:0]            dot_next;

   // A request moves into the response register whenever the response slot is free
   // or is being emptied in the same cycle, so the two stages run back to back.
   assign exec_fire = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (exec_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign last_line_in = csr_write_enable ? csr_write_data : last_line_ff;

   assign bg_on     = mask_ff[3];
   assign render_on = mask_ff[3] | mask_ff[4];
   assign both_on   = mask_ff[3] & mask_ff[4];

   // Coarse X steps at the last pixel of each tile: (fine_x + dot - 1) mod 8 == 7,
   // which is the same as (fine_x + dot) mod 8 == 0.
   assign fine_sum   = fine_x_ff + dot_ff[2:0];
   assign coarse_hit = (dot_ff != '0) && (dot_ff <= VisibleWidth) && (fine_sum == 3'd0);

   // Main update. Everything holds unless a request is being executed.
   always_comb begin
      cur_addr_in = cur_addr_ff;
      tmp_addr_in = tmp_addr_ff;
      fine_x_in   = fine_x_ff;
      first_wr_in = first_wr_ff;
      ctrl_in     = ctrl_ff;
      mask_in     = mask_ff;
      vblank_in   = vblank_ff;
      dot_in      = dot_ff;
      line_in     = line_ff;
      odd_in      = odd_ff;
      status_in   = 8'd0;
      frame_in    = 1'b0;
      pulse_in    = 1'b0;
      dot_eff     = dot_ff;
      dot_next    = {1'b0, dot_ff} + 10'd1;

      if (exec_fire) begin
         unique case (s1_op_ff)
            OP_TICK: begin
               if (line_ff < VisibleLines) begin
                  // Visible line: horizontal stepping, end-of-line Y step, reload and the mid-line pulse.
                  if (coarse_hit && bg_on) begin
                     cur_addr_in = step_coarse_x(cur_addr_ff);
                  end
                  if (dot_ff == StepYDot && bg_on) begin
                     cur_addr_in = step_y(cur_addr_ff);
                  end else if (dot_ff == HorizDot && render_on) begin
                     cur_addr_in = copy_bits(cur_addr_ff, tmp_addr_ff, HorizBits);
                  end else if (dot_ff == PulseDot && both_on) begin
                     pulse_in = 1'b1;
                  end
               end else if (line_ff == VisibleLines) begin
                  // The post-render line does nothing.
               end else if (line_ff < last_line_ff) begin
                  if (dot_ff == 9'd1 && line_ff == VblankLine) begin
                     vblank_in = 1'b1;
                  end
               end else begin
                  // Pre-render line: clear vblank, reload scroll, mid-line pulse, maybe skip a dot, end the frame.
                  if (dot_ff == 9'd1) begin
                     vblank_in = 1'b0;
                  end else if (dot_ff == HorizDot && render_on) begin
                     cur_addr_in = copy_bits(cur_addr_ff, tmp_addr_ff, HorizBits);
                  end else if (dot_ff == PulseDot && both_on) begin
                     pulse_in = 1'b1;
                  end else if (dot_ff >= VertFirstDot && dot_ff <= VertLastDot && render_on) begin
                     cur_addr_in = copy_bits(cur_addr_ff, tmp_addr_ff, VertBits);
                  end else if (dot_ff == SkipDot && odd_ff && render_on) begin
                     dot_eff = dot_ff + 9'd1;
                  end
                  if (dot_eff >= LastDot) begin
                     frame_in = 1'b1;
                     odd_in   = ~odd_ff;
                  end
               end
               dot_next = {1'b0, dot_eff} + 10'd1;
               if (dot_next >= DotsPerLine) begin
                  dot_in  = '0;
                  line_in = (line_ff >= last_line_ff) ? '0 : line_ff + 9'd1;
               end else begin
                  dot_in = dot_next[CountWidth-1:0];
               end
            end
            OP_CTRL: begin
               ctrl_in            = s1_data_ff;
               tmp_addr_in[11:10] = s1_data_ff[1:0];
            end
            OP_MASK: begin
               mask_in = s1_data_ff;
            end
            OP_STATUS: begin
               status_in   = {vblank_ff, 7'd0};
               first_wr_in = 1'b1;
               vblank_in   = 1'b0;
            end
            OP_SCROLL: begin
               if (first_wr_ff) begin
                  tmp_addr_in[4:0] = s1_data_ff[7:3];
                  fine_x_in        = s1_data_ff[2:0];
                  first_wr_in      = 1'b0;
               end else begin
                  tmp_addr_in[14:12] = s1_data_ff[2:0];
                  tmp_addr_in[9:5]   = s1_data_ff[7:3];
                  first_wr_in        = 1'b1;
               end
            end
            OP_ADDR: begin
               if (first_wr_ff) begin
                  tmp_addr_in[14]   = 1'b0;
                  tmp_addr_in[13:8] = s1_data_ff[5:0];
                  first_wr_in       = 1'b0;
               end else begin
                  tmp_addr_in[7:0] = s1_data_ff;
                  cur_addr_in      = {tmp_addr_ff[14:8], s1_data_ff};
                  first_wr_in      = 1'b1;
               end
            end
            OP_DATA: begin
               cur_addr_in = cur_addr_ff + (ctrl_ff[2] ? 15'd32 : 15'd1);
            end
            default: begin
               // The unused code only reports the current state.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_line_ff <= ResetLine;
         cur_addr_ff  <= '0;
         tmp_addr_ff  <= '0;
         fine_x_ff    <= '0;
         first_wr_ff  <= 1'b1;
         ctrl_ff      <= '0;
         mask_ff      <= '0;
         vblank_ff    <= 1'b0;
         dot_ff       <= '0;
         line_ff      <= ResetLine;
         odd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_line_ff <= last_line_in;
         cur_addr_ff  <= cur_addr_in;
         tmp_addr_ff  <= tmp_addr_in;
         fine_x_ff    <= fine_x_in;
         first_wr_ff  <= first_wr_in;
         ctrl_ff      <= ctrl_in;
         mask_ff      <= mask_in;
         vblank_ff    <= vblank_in;
         dot_ff       <= dot_in;
         line_ff      <= line_in;
         odd_ff       <= odd_in;
      end
   end

   // Payload registers carry no reset; they are qualified by the valid flags.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= op_type'(req_operation);
         s1_data_ff <= req_data_byte;
      end
      if (exec_fire) begin
         out_addr_ff   <= cur_addr_in;
         out_fine_x_ff <= fine_x_in;
         out_nmi_ff    <= ctrl_in[7] & vblank_in;
         out_status_ff <= status_in;
         out_frame_ff  <= frame_in;
         out_pulse_ff  <= pulse_in;
         out_dot_ff    <= dot_in;
         out_line_ff   <= line_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_vram_address   = out_addr_ff;
   assign rsp_fine_scroll_x  = out_fine_x_ff;
   assign rsp_nmi_level      = out_nmi_ff;
   assign rsp_status_data    = out_status_ff;
   assign rsp_frame_done     = out_frame_ff;
   assign rsp_scanline_pulse = out_pulse_ff;
   assign rsp_dot_index      = out_dot_ff;
   assign rsp_scanline_index = out_line_ff;

   // The dot counter never leaves the line.
   a_dot_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, dot_ff} < DotsPerLine)
      else $error("dot counter out of range");

   // The frame end always coincides with the dot counter wrapping.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_frame_ff |-> out_dot_ff == '0)
      else $error("frame end without dot wrap");

   // The mid-line pulse is reported on the dot after the pulse dot.
   a_pulse_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_pulse_ff |-> out_dot_ff == PulseDot + 9'd1)
      else $error("scanline pulse at wrong dot");

   // A status read leaves vblank clear and the write toggle set.
   a_status_clear: assert property (@(posedge clock) disable iff (reset)
      exec_fire && s1_op_ff == OP_STATUS |=> !vblank_ff && first_wr_ff)
      else $error("status read did not clear vblank");

endmodule
